FILE: rtl/text_console_cell_writer_core_macros.svh
// ----------------------------------------------------------------------------
// Text console cell writer assertion macros
// Shared assertion wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define TCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TCW_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define TCW_ASSERT(label, prop, msg)
`define TCW_ASSERT_NEVER(label, expr, msg)
`endif

`endif

FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console cell writer package
// Request and response payloads, control character codes, action codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	localparam logic CFG_FOREGROUND = 1'b0;
	localparam logic CFG_BACKGROUND = 1'b1;

	localparam logic [3:0] FG_RESET = 4'd7;
	localparam logic [3:0] BG_RESET = 4'd0;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} req_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [10:0] cursor_pos;
	} rsp_t;

	typedef struct packed {
		logic wr_en;
		logic wr_blank;
		logic wr_prev;
		logic scroll;
	} step_t;

endpackage

FILE: rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// Text console screen memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/tcw_cursor_step.sv
// ----------------------------------------------------------------------------
// Text console cursor step
// Next cursor position and cell write for one put request.
// ----------------------------------------------------------------------------
module tcw_cursor_step #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	localparam int ROW_W  = $clog2(ROWS),
	localparam int COL_W  = $clog2(COLUMNS)
) (
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W-1:0]    col,
	input  logic [7:0]          char_code,
	output logic [ROW_W-1:0]    next_row,
	output logic [COL_W-1:0]    next_col,
	output tcw_pkg::step_t      step
);

	localparam logic [COL_W:0]   COL_LIMIT = (COL_W+1)'(COLUMNS);
	localparam logic [COL_W:0]   TAB_STEP  = (COL_W+1)'(8);
	localparam logic [COL_W:0]   TAB_MASK  = ~((COL_W+1)'(7));
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

	logic [COL_W:0] col_inc;
	logic [COL_W:0] tab_col;
	logic           inc_row;

	assign col_inc = {1'b0, col} + (COL_W+1)'(1);
	assign tab_col = ({1'b0, col} + TAB_STEP) & TAB_MASK;

	always_comb begin
		step     = '0;
		next_col = col;
		inc_row  = 1'b0;
		case (char_code)
			tcw_pkg::CH_NEWLINE: begin
				next_col = '0;
				inc_row  = 1'b1;
			end
			tcw_pkg::CH_RETURN: begin
				next_col = '0;
			end
			tcw_pkg::CH_BACKSPACE: begin
				if (col != '0) begin
					next_col      = col - COL_W'(1);
					step.wr_en    = 1'b1;
					step.wr_blank = 1'b1;
					step.wr_prev  = 1'b1;
				end
			end
			tcw_pkg::CH_TAB: begin
				if (tab_col >= COL_LIMIT) begin
					next_col = '0;
					inc_row  = 1'b1;
				end else begin
					next_col = tab_col[COL_W-1:0];
				end
			end
			default: begin
				step.wr_en = 1'b1;
				if (col_inc >= COL_LIMIT) begin
					next_col = '0;
					inc_row  = 1'b1;
				end else begin
					next_col = col_inc[COL_W-1:0];
				end
			end
		endcase
		step.scroll = inc_row && (row == ROW_LAST);
		next_row    = (inc_row && !step.scroll) ? row + ROW_W'(1) : row;
	end

endmodule

FILE: rtl/text_console_cell_writer_core.sv
// ----------------------------------------------------------------------------
// Text console cell writer core
// The result is strobed in the cycle after a plain put; an in-range read goes
// through ST_READ first. Clear and scroll write one cell per cycle through the
// single write port of the screen memory. A new request is taken in the cycle
// the previous result is strobed. Reset homes the cursor and loads colors
// 7 on 0; screen contents stay undefined until the first clear.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_core_macros.svh"

module text_console_cell_writer_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  tcw_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output tcw_pkg::rsp_t rsp,
	input  logic          cfg_wr_en,
	input  logic          cfg_index,
	input  logic [3:0]    cfg_data
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [ADDR_W-1:0] COL_MULT  = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_COPY  = 3'd2;
	localparam logic [2:0] ST_FILL  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]        state_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              done_q;
	logic [3:0]        fg_q;
	logic [3:0]        bg_q;
	logic [15:0]       cell_q;

	logic              wr_vld_s1;
	logic              wr_copy_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic [ROW_W-1:0]  next_row;
	logic [COL_W-1:0]  next_col;
	tcw_pkg::step_t    step;

	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] req_addr;
	logic              rd_in_range;
	logic [15:0]       blank;
	logic              accept;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	tcw_cursor_step #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_step (
		.row       (cur_row_q),
		.col       (cur_col_q),
		.char_code (req.char_code),
		.next_row  (next_row),
		.next_col  (next_col),
		.step      (step)
	);

	tcw_screen_ram #(
		.DEPTH  (CELLS),
		.ADDR_W (ADDR_W),
		.DATA_W (16)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign blank  = {bg_q, fg_q, tcw_pkg::CH_SPACE};

	assign cur_addr    = ADDR_W'(cur_row_q * COL_MULT) + ADDR_W'(cur_col_q);
	assign req_addr    = ADDR_W'(ADDR_W'(req.read_row) * COL_MULT) + ADDR_W'(req.read_col);
	assign rd_in_range = (32'(req.read_row) < ROWS) && (32'(req.read_col) < COLUMNS);
	assign ram_raddr   = (state_q == ST_COPY) ? cnt_q + COL_MULT : req_addr;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = blank;
		if (wr_vld_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = wr_copy_s1 ? ram_rdata : blank;
		end else if (accept && (req.action == tcw_pkg::ACT_PUT) && step.wr_en) begin
			ram_we    = 1'b1;
			ram_waddr = step.wr_prev ? cur_addr - ADDR_W'(1) : cur_addr;
			ram_wdata = step.wr_blank ? blank : {bg_q, fg_q, req.char_code};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_row_q <= '0;
			cur_col_q <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			wr_vld_s1 <= 1'b0;
			fg_q      <= tcw_pkg::FG_RESET;
			bg_q      <= tcw_pkg::BG_RESET;
		end else begin
			done_q    <= 1'b0;
			wr_vld_s1 <= 1'b0;
			if (cfg_wr_en) begin
				case (cfg_index)
					tcw_pkg::CFG_FOREGROUND: fg_q <= cfg_data;
					tcw_pkg::CFG_BACKGROUND: bg_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (req.action)
							tcw_pkg::ACT_PUT: begin
								cur_row_q <= next_row;
								cur_col_q <= next_col;
								cnt_q     <= '0;
								if (step.scroll) begin
									state_q <= ST_COPY;
								end else begin
									done_q <= 1'b1;
								end
							end
							tcw_pkg::ACT_CLEAR: begin
								cur_row_q <= '0;
								cur_col_q <= '0;
								cnt_q     <= '0;
								state_q   <= ST_FILL;
							end
							tcw_pkg::ACT_READ: begin
								if (rd_in_range) begin
									state_q <= ST_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_COPY: begin
					wr_vld_s1 <= 1'b1;
					cnt_q     <= cnt_q + ADDR_W'(1);
					if (cnt_q == COPY_LAST) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					wr_vld_s1 <= 1'b1;
					cnt_q     <= cnt_q + ADDR_W'(1);
					if (cnt_q == CELL_LAST) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= cnt_q;
		wr_copy_s1 <= (state_q == ST_COPY);
		if (accept) begin
			cell_q <= '0;
		end else if (state_q == ST_READ) begin
			cell_q <= ram_rdata;
		end
	end

	assign rsp.cell_value = cell_q;
	assign rsp.cursor_row = 5'(cur_row_q);
	assign rsp.cursor_col = 7'(cur_col_q);
	assign rsp.cursor_pos = 11'(cur_addr);

	`TCW_ASSERT(a_done_idle, done |-> !busy, "result strobed while busy")
	`TCW_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done), "request dropped")
	`TCW_ASSERT_NEVER(a_write_clash, wr_vld_s1 && !busy, "pipelined write outside sweep")
	`TCW_ASSERT(a_cursor_range, (32'(cur_col_q) < COLUMNS) && (32'(cur_row_q) < ROWS), "cursor off screen")

endmodule
